[design/countdown_timer_bank_defines.svh]
// Assertion macros for the countdown timer bank.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define COUNTDOWN_TIMER_BANK_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define CTB_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CTB_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

  // Width of a seconds count and of a warning threshold.
  localparam int TimeW = 32;
  // Width of the slot field in a result.
  localparam int SlotW = 4;
  // Zero bits that round the result data up to whole bytes.
  localparam int OutPadW = 4;
  localparam int InDataW = 2 * TimeW;
  localparam int OutDataW = SlotW + TimeW + OutPadW;

  // Request kinds carried in the input tuser.
  localparam logic ActAdd = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef enum logic [2:0] {
    KindAdded   = 3'd0,
    KindRefused = 3'd1,
    KindWarning = 3'd2,
    KindExpired = 3'd3,
    KindDone    = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StAdd   = 5'b00010,
    StRead  = 5'b00100,
    StCheck = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  // Verdict of the shared decrement and compare unit.
  typedef struct packed {
    logic             zero;
    logic             warn;
    logic [TimeW-1:0] next;
  } dec_res_t;

endpackage

`default_nettype wire

[design/ctb_store.sv]
`default_nettype none

module ctb_store import ctb_pkg::*; #(
  parameter int Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rem_we_i,
  input  wire logic                                  thr_we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  wire logic [TimeW-1:0]                      wr_rem_i,
  input  wire logic [TimeW-1:0]                      wr_thr_i,
  input  wire logic                                  rd_en_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic      [TimeW-1:0]                      rd_rem_o,
  output logic      [TimeW-1:0]                      rd_thr_o
);

  logic [TimeW-1:0] rem_mem [Depth];
  logic [TimeW-1:0] thr_mem [Depth];
  logic [TimeW-1:0] rd_rem_q;
  logic [TimeW-1:0] rd_thr_q;

  // One write and one registered read per cycle on each store.
  always_ff @(posedge clk_i) begin
    if (rem_we_i) begin
      rem_mem[wr_addr_i] <= wr_rem_i;
    end
    if (thr_we_i) begin
      thr_mem[wr_addr_i] <= wr_thr_i;
    end
    if (rd_en_i) begin
      rd_rem_q <= rem_mem[rd_addr_i];
      rd_thr_q <= thr_mem[rd_addr_i];
    end
  end

  assign rd_rem_o = rd_rem_q;
  assign rd_thr_o = rd_thr_q;

endmodule

`default_nettype wire

[design/ctb_dec_unit.sv]
`default_nettype none

module ctb_dec_unit import ctb_pkg::*; (
  input  wire logic [TimeW-1:0] rem_i,
  input  wire logic [TimeW-1:0] thr_i,
  output dec_res_t              res_o
);

  logic [TimeW-1:0] next;
  logic             zero;

  // A running timer loses one second and warns when it lands on its threshold.
  assign zero = (rem_i == '0);
  assign next = rem_i - TimeW'(1);

  assign res_o.zero = zero;
  assign res_o.next = next;
  assign res_o.warn = !zero && (next == thr_i);

endmodule

`default_nettype wire

[design/countdown_timer_bank.sv]
// An add request gives its single result from the add state through the output register.
// A tick request walks the stored timers in order: read, then one check per timer visited
// through the shared decrement and compare unit, then done; an expired timer ends the walk early.
// Input ready is low until a request is finished; results wait while the output register is full.
// Reset (rst_ni low, asynchronous) empties the bank and drops any pending result.
`default_nettype none
`include "countdown_timer_bank_defines.svh"

module countdown_timer_bank import ctb_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // Fields from bit 0 up: start_seconds [31:0], warn_seconds [63:32].
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // Fields: action [0] (0 adds a timer, 1 is a one-second tick).
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // Fields from bit 0 up: timer_slot [3:0], warn_value [35:4], zero padding [39:36].
  output logic      [OutDataW-1:0] m_axis_tdata_o,
  // Fields: event_kind [2:0].
  output logic      [2:0]          m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  // Index width addresses the stores; the count width can also hold the full count.
  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CntW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsC = CntW'(TIMER_SLOTS);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  idx_next;
  logic [TimeW-1:0] start_q;
  logic [TimeW-1:0] warn_q;

  // Store port controls.
  logic             rem_we;
  logic             thr_we;
  logic [IdxW-1:0]  wr_addr;
  logic [TimeW-1:0] wr_rem;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [TimeW-1:0] rd_rem;
  logic [TimeW-1:0] rd_thr;
  dec_res_t         dec_res;

  // Output register, loaded by the sequencer when the slot is free.
  logic             out_valid_q;
  logic [2:0]       out_kind_q;
  logic [SlotW-1:0] out_slot_q;
  logic [TimeW-1:0] out_warn_q;
  logic             out_last_q;
  logic             out_free;
  logic             out_load;
  kind_e            out_kind;
  logic [SlotW-1:0] out_slot;
  logic [TimeW-1:0] out_warn;
  logic             out_last;
  logic             in_accept;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  // A result may be written when the register is empty or drains in this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign idx_next = idx_q + CntW'(1);

  ctb_store #(
    .Depth(TIMER_SLOTS)
  ) u_store (
    .clk_i    (clk_i),
    .rem_we_i (rem_we),
    .thr_we_i (thr_we),
    .wr_addr_i(wr_addr),
    .wr_rem_i (wr_rem),
    .wr_thr_i (warn_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_rem_o (rd_rem),
    .rd_thr_o (rd_thr)
  );

  ctb_dec_unit u_dec (
    .rem_i(rd_rem),
    .thr_i(rd_thr),
    .res_o(dec_res)
  );

  // Sequencer. A tick walks the slots in order, one per cycle in the check
  // state: the timer under test is written back while the next slot is read,
  // so the store's read latency is hidden after the first slot. The walk stalls
  // only when a warning or an expiry has to wait for the output register.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    rem_we   = 1'b0;
    thr_we   = 1'b0;
    wr_addr  = idx_q[IdxW-1:0];
    wr_rem   = dec_res.next;
    rd_en    = 1'b0;
    rd_addr  = idx_q[IdxW-1:0];
    out_load = 1'b0;
    out_kind = KindDone;
    out_slot = '0;
    out_warn = '0;
    out_last = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          idx_d = '0;
          if (s_axis_tuser_i == ActAdd) begin
            state_d = StAdd;
          end else begin
            state_d = StRead;
          end
        end
      end
      StAdd: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          state_d  = StIdle;
          if (count_q == SlotsC) begin
            // The bank is full: nothing is stored and the request is refused.
            out_kind = KindRefused;
          end else begin
            out_kind = KindAdded;
            out_slot = SlotW'(count_q);
            rem_we   = 1'b1;
            thr_we   = 1'b1;
            wr_addr  = count_q[IdxW-1:0];
            wr_rem   = start_q;
            count_d  = count_q + CntW'(1);
          end
        end
      end
      StRead: begin
        if (count_q == '0) begin
          state_d = StDone;
        end else begin
          rd_en   = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (dec_res.zero) begin
          // The first timer found at zero expires and ends the walk.
          if (out_free) begin
            out_load = 1'b1;
            out_kind = KindExpired;
            out_slot = SlotW'(idx_q);
            state_d  = StDone;
          end
        end else if (!dec_res.warn || out_free) begin
          rem_we = 1'b1;
          if (dec_res.warn) begin
            out_load = 1'b1;
            out_kind = KindWarning;
            out_slot = SlotW'(idx_q);
            out_warn = rd_thr;
          end
          idx_d = idx_next;
          if (idx_next < count_q) begin
            rd_en   = 1'b1;
            rd_addr = idx_next[IdxW-1:0];
          end else begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = KindDone;
          out_last = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload and result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      start_q <= s_axis_tdata_i[TimeW-1:0];
      warn_q  <= s_axis_tdata_i[InDataW-1:TimeW];
    end
    if (out_load) begin
      out_kind_q <= out_kind;
      out_slot_q <= out_slot;
      out_warn_q <= out_warn;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {OutPadW'(0), out_warn_q, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  `CTB_ASSERT_HOLDS(a_count_bound, count_q <= SlotsC, "timer count beyond bank size")
  `CTB_ASSERT_IMPLIES(a_walk_range, state_q == StCheck, idx_q < count_q, "walk past last timer")
  `CTB_ASSERT_IMPLIES(a_no_zero_wb, (state_q == StCheck) && rem_we, !dec_res.zero, "expired timer written back")
  `CTB_ASSERT_NEXT(a_done_idle, (state_q == StDone) && out_free, state_q == StIdle, "tick did not finish")
  `CTB_ASSERT_NEXT(a_add_count, (state_q == StAdd) && out_free && (count_q != SlotsC), count_q == $past(count_q) + 1'b1, "add did not take a slot")

endmodule

`default_nettype wire
